FILE: hdl/wts_pkg.sv
// shared widths, config register indexes and pipeline side-band type for the projection block
package wts_pkg;

  localparam int CfgW    = 63;
  localparam int CfgIdxW = 3;

  localparam logic [CfgIdxW-1:0] CfgCamera  = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgRight   = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgUp      = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgForward = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgScales  = 3'd4;
  localparam logic [CfgIdxW-1:0] CfgView    = 3'd5;
  localparam logic [CfgIdxW-1:0] CfgEnable  = 3'd6;

  localparam int CoordW = 21;
  localparam int DiffW  = 22;
  localparam int AxisW  = 16;
  localparam int ProdW  = 38;
  localparam int DotW   = 40;
  localparam int MagW   = 38;
  localparam int ScaleW = 24;
  localparam int SizeW  = 16;
  localparam int PartW  = 43;
  localparam int PrW    = 62;
  localparam int Part2W = 47;
  localparam int NumW   = 80;
  localparam int DenW   = 52;
  localparam int QuotW  = 23;
  localparam int DepthW = 31;
  localparam int ScrW   = 20;
  localparam int SumW   = 26;

  localparam logic [QuotW-1:0] OffCap  = 23'h400000;
  localparam logic [DotW-1:0]  WqMin   = 40'd17;

  typedef struct packed {
    logic              ok;
    logic              neg_x;
    logic              neg_y;
    logic [DepthW-1:0] depth;
  } side_t;

endpackage

FILE: hdl/wts_point_if.sv
// handshake channels for world points in and projected results out
interface wts_point_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [wts_pkg::CoordW-1:0]    world_x;
  logic signed [wts_pkg::CoordW-1:0]    world_y;
  logic signed [wts_pkg::CoordW-1:0]    world_z;
  modport source (output valid, world_x, world_y, world_z, input ready);
  modport sink   (input valid, world_x, world_y, world_z, output ready);
endinterface

interface wts_result_if;
  logic                                 valid;
  logic                                 ready;
  logic                                 projected_ok;
  logic signed [wts_pkg::ScrW-1:0]      screen_x;
  logic signed [wts_pkg::ScrW-1:0]      screen_y;
  logic [wts_pkg::DepthW-1:0]           depth;
  logic                                 on_screen;
  modport source (output valid, projected_ok, screen_x, screen_y, depth, on_screen,
                  input ready);
  modport sink   (input valid, projected_ok, screen_x, screen_y, depth, on_screen,
                  output ready);
endinterface

FILE: hdl/wts_div.sv
// pipelined restoring divider, one quotient bit per stage, with overflow flag
module wts_div (
  input  logic                        clk_i,
  input  logic                        en_i,
  input  logic [wts_pkg::NumW-1:0]    num_i,
  input  logic [wts_pkg::DenW-1:0]    den_i,
  output logic [wts_pkg::QuotW-1:0]   quot_o,
  output logic                        cap_o
);

  localparam int NSt = wts_pkg::QuotW;
  localparam int PadW = wts_pkg::NumW - wts_pkg::DenW;

  logic [wts_pkg::NumW-1:0]  rem_q  [NSt];
  logic [wts_pkg::NumW-1:0]  rem_d  [NSt];
  logic [wts_pkg::DenW-1:0]  den_q  [NSt];
  logic [wts_pkg::DenW-1:0]  den_d  [NSt];
  logic [wts_pkg::QuotW-1:0] quot_q [NSt];
  logic [wts_pkg::QuotW-1:0] quot_d [NSt];
  logic                      cap_q  [NSt];
  logic                      cap_d  [NSt];

  always_comb begin
    logic [wts_pkg::NumW-1:0]  rin;
    logic [wts_pkg::NumW-1:0]  dsh;
    logic [wts_pkg::QuotW-1:0] qin;
    logic                      ge;
    for (int j = 0; j < NSt; j++) begin
      if (j == 0) begin
        rin      = num_i;
        den_d[j] = den_i;
        qin      = '0;
        cap_d[j] = (num_i >= ({{PadW{1'b0}}, den_i} << NSt));
      end else begin
        rin      = rem_q[j-1];
        den_d[j] = den_q[j-1];
        qin      = quot_q[j-1];
        cap_d[j] = cap_q[j-1];
      end
      dsh       = {{PadW{1'b0}}, den_d[j]} << (NSt - 1 - j);
      ge        = (rin >= dsh);
      rem_d[j]  = ge ? (rin - dsh) : rin;
      quot_d[j] = qin | ({{(wts_pkg::QuotW-1){1'b0}}, ge} << (NSt - 1 - j));
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int j = 0; j < NSt; j++) begin
        rem_q[j]  <= rem_d[j];
        den_q[j]  <= den_d[j];
        quot_q[j] <= quot_d[j];
        cap_q[j]  <= cap_d[j];
      end
    end
  end

  assign quot_o = quot_q[NSt-1];
  assign cap_o  = cap_q[NSt-1];

endmodule

FILE: hdl/world_to_screen_projection.sv
// top level of the world-to-screen perspective projection pipeline
// A new point may be offered every cycle and one result leaves every cycle while the
// result register is free or being taken. From acceptance to the result register lie
// eight arithmetic stages (offset from camera, the nine axis products, the dot sums,
// magnitude and depth, two split multiplications by scale and by viewport size), a
// 23-stage divider that produces one quotient bit per stage against the depth, and a
// final stage that adds the centre, clamps and judges the viewport. The whole pipeline
// advances together whenever the result register is empty or being taken, so a stall
// freezes every stage and loses no item. Configuration is taken directly from the
// registers and must only change while the pipeline holds no item.
module world_to_screen_projection (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [wts_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [wts_pkg::CfgW-1:0]      cfg_data_i,
  wts_point_if.sink                     pt_i,
  wts_result_if.source                  res_o
);

  // configuration registers
  logic [62:0] cam_q;
  logic [47:0] right_q, up_q, fwd_q, scale_q;
  logic [31:0] view_q;
  logic        enable_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cam_q    <= '0;
      right_q  <= '0;
      up_q     <= '0;
      fwd_q    <= '0;
      scale_q  <= '0;
      view_q   <= '0;
      enable_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        wts_pkg::CfgCamera:  cam_q    <= cfg_data_i;
        wts_pkg::CfgRight:   right_q  <= cfg_data_i[47:0];
        wts_pkg::CfgUp:      up_q     <= cfg_data_i[47:0];
        wts_pkg::CfgForward: fwd_q    <= cfg_data_i[47:0];
        wts_pkg::CfgScales:  scale_q  <= cfg_data_i[47:0];
        wts_pkg::CfgView:    view_q   <= cfg_data_i[31:0];
        wts_pkg::CfgEnable:  enable_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  logic [wts_pkg::SizeW-1:0]  vp_w, vp_h;
  logic [wts_pkg::ScaleW-1:0] hs, vs;
  assign vp_w = view_q[31:16];
  assign vp_h = view_q[15:0];
  assign hs   = scale_q[47:24];
  assign vs   = scale_q[23:0];

  // global advance: whole pipe moves when the output slot is free or being emptied
  logic out_vld_q;
  logic en;
  assign en       = !out_vld_q || res_o.ready;
  assign pt_i.ready = en;

  // valid bits travelling with the data
  localparam int NVld = 8;
  logic [NVld-1:0] vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[NVld-2:0], pt_i.valid};
    end
  end

  // stage 1: offset from camera
  logic signed [wts_pkg::DiffW-1:0] dif_q [3];
  logic signed [wts_pkg::DiffW-1:0] dif_d [3];

  always_comb begin
    dif_d[0] = {pt_i.world_x[20], pt_i.world_x} - {cam_q[62], cam_q[62:42]};
    dif_d[1] = {pt_i.world_y[20], pt_i.world_y} - {cam_q[41], cam_q[41:21]};
    dif_d[2] = {pt_i.world_z[20], pt_i.world_z} - {cam_q[20], cam_q[20:0]};
  end

  // stage 2: nine axis products, rows right, up, forward
  logic signed [wts_pkg::ProdW-1:0] prd_q [9];
  logic [47:0] axes [3];
  assign axes[0] = right_q;
  assign axes[1] = up_q;
  assign axes[2] = fwd_q;

  // stage 3: dot sums
  logic signed [wts_pkg::DotW-1:0] xq_q, yq_q, wq_q;

  // stage 4: magnitudes, depth test, depth value
  wts_pkg::side_t          side4_q, side4_d;
  logic [wts_pkg::MagW-1:0] mx4_q, my4_q, wq4_q;
  logic [wts_pkg::DotW-1:0] ax_abs, ay_abs;
  logic [32:0]              dep_full;

  always_comb begin
    ax_abs         = xq_q[wts_pkg::DotW-1] ? -xq_q : xq_q;
    ay_abs         = yq_q[wts_pkg::DotW-1] ? -yq_q : yq_q;
    dep_full       = 33'((wq_q[38:0] + 39'd32) >> 6);
    side4_d.ok     = enable_q && (wq_q >= $signed(wts_pkg::WqMin));
    side4_d.neg_x  = xq_q[wts_pkg::DotW-1];
    side4_d.neg_y  = yq_q[wts_pkg::DotW-1];
    side4_d.depth  = (dep_full[32:31] != 2'b00) ? {wts_pkg::DepthW{1'b1}} : dep_full[30:0];
  end

  // stage 5: magnitude times perspective scale, split in two halves
  wts_pkg::side_t            side5_q;
  logic [wts_pkg::PartW-1:0] hx5_q, lx5_q, hy5_q, ly5_q;
  logic [wts_pkg::MagW-1:0]  wq5_q;

  // stage 6: recombine
  wts_pkg::side_t          side6_q;
  logic [wts_pkg::PrW-1:0] px6_q, py6_q;
  logic [wts_pkg::MagW-1:0] wq6_q;

  // stage 7: times viewport size, split in two halves
  wts_pkg::side_t             side7_q;
  logic [wts_pkg::Part2W-1:0] hx7_q, lx7_q, hy7_q, ly7_q;
  logic [wts_pkg::MagW-1:0]   wq7_q;

  // stage 8: rounded dividend 2n + c and divisor 2c, c = 8192 * w
  wts_pkg::side_t           side8_q;
  logic [wts_pkg::NumW-1:0] nx8_q, ny8_q;
  logic [wts_pkg::DenW-1:0] den8_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < 3; k++) dif_q[k] <= dif_d[k];
      for (int a = 0; a < 3; a++) begin
        for (int c = 0; c < 3; c++) begin
          prd_q[a*3+c] <= wts_pkg::ProdW'($signed(axes[a][47-16*c -: 16]) * dif_q[c]);
        end
      end
      xq_q <= wts_pkg::DotW'(prd_q[0]) + wts_pkg::DotW'(prd_q[1]) + wts_pkg::DotW'(prd_q[2]);
      yq_q <= wts_pkg::DotW'(prd_q[3]) + wts_pkg::DotW'(prd_q[4]) + wts_pkg::DotW'(prd_q[5]);
      wq_q <= wts_pkg::DotW'(prd_q[6]) + wts_pkg::DotW'(prd_q[7]) + wts_pkg::DotW'(prd_q[8]);

      side4_q <= side4_d;
      mx4_q   <= ax_abs[wts_pkg::MagW-1:0];
      my4_q   <= ay_abs[wts_pkg::MagW-1:0];
      wq4_q   <= wq_q[wts_pkg::MagW-1:0];

      side5_q <= side4_q;
      wq5_q   <= wq4_q;
      hx5_q   <= wts_pkg::PartW'(mx4_q[37:19] * hs);
      lx5_q   <= wts_pkg::PartW'(mx4_q[18:0] * hs);
      hy5_q   <= wts_pkg::PartW'(my4_q[37:19] * vs);
      ly5_q   <= wts_pkg::PartW'(my4_q[18:0] * vs);

      side6_q <= side5_q;
      wq6_q   <= wq5_q;
      px6_q   <= (wts_pkg::PrW'(hx5_q) << 19) + wts_pkg::PrW'(lx5_q);
      py6_q   <= (wts_pkg::PrW'(hy5_q) << 19) + wts_pkg::PrW'(ly5_q);

      side7_q <= side6_q;
      wq7_q   <= wq6_q;
      hx7_q   <= wts_pkg::Part2W'(px6_q[61:31] * vp_w);
      lx7_q   <= wts_pkg::Part2W'(px6_q[30:0] * vp_w);
      hy7_q   <= wts_pkg::Part2W'(py6_q[61:31] * vp_h);
      ly7_q   <= wts_pkg::Part2W'(py6_q[30:0] * vp_h);

      side8_q <= side7_q;
      nx8_q   <= ((wts_pkg::NumW'(hx7_q) << 31) + wts_pkg::NumW'(lx7_q)) * 2
                 + (wts_pkg::NumW'(wq7_q) << 13);
      ny8_q   <= ((wts_pkg::NumW'(hy7_q) << 31) + wts_pkg::NumW'(ly7_q)) * 2
                 + (wts_pkg::NumW'(wq7_q) << 13);
      den8_q  <= wts_pkg::DenW'(wq7_q) << 14;
    end
  end

  // dividers for the two screen offsets
  logic [wts_pkg::QuotW-1:0] qx, qy;
  logic                      capx, capy;

  wts_div u_div_x (
    .clk_i  (clk_i),
    .en_i   (en),
    .num_i  (nx8_q),
    .den_i  (den8_q),
    .quot_o (qx),
    .cap_o  (capx)
  );

  wts_div u_div_y (
    .clk_i  (clk_i),
    .en_i   (en),
    .num_i  (ny8_q),
    .den_i  (den8_q),
    .quot_o (qy),
    .cap_o  (capy)
  );

  // side-band and valid delay line matching the divider depth
  localparam int DivLat = wts_pkg::QuotW;
  wts_pkg::side_t    sdl_q [DivLat];
  logic [DivLat-1:0] vdl_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      sdl_q[0] <= side8_q;
      for (int k = 1; k < DivLat; k++) sdl_q[k] <= sdl_q[k-1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vdl_q <= '0;
    end else if (en) begin
      vdl_q <= {vdl_q[DivLat-2:0], vld_q[NVld-1]};
    end
  end

  // final stage: cap the offset, add the screen centre, clamp, judge the viewport
  wts_pkg::side_t            sf;
  logic [wts_pkg::QuotW-1:0] offx, offy;
  logic signed [wts_pkg::SumW-1:0] sx, sy, offxs, offys;
  logic                      on_d;
  logic signed [wts_pkg::ScrW-1:0] cx, cy;

  function automatic logic signed [wts_pkg::ScrW-1:0] clamp20(
    input logic signed [wts_pkg::SumW-1:0] v
  );
    logic signed [wts_pkg::SumW-1:0] hi;
    logic signed [wts_pkg::SumW-1:0] lo;
    hi = wts_pkg::SumW'(524287);
    lo = -wts_pkg::SumW'(524288);
    if (v > hi)      return wts_pkg::ScrW'(hi);
    else if (v < lo) return wts_pkg::ScrW'(lo);
    else             return v[wts_pkg::ScrW-1:0];
  endfunction

  always_comb begin
    sf    = sdl_q[DivLat-1];
    offx  = (capx || qx > wts_pkg::OffCap) ? wts_pkg::OffCap : qx;
    offy  = (capy || qy > wts_pkg::OffCap) ? wts_pkg::OffCap : qy;
    offxs = $signed(wts_pkg::SumW'(offx));
    offys = $signed(wts_pkg::SumW'(offy));
    // x grows right from the left edge, y grows down from the top edge
    sx    = $signed(wts_pkg::SumW'({vp_w, 3'b000})) + (sf.neg_x ? -offxs : offxs);
    sy    = $signed(wts_pkg::SumW'({vp_h, 3'b000})) - (sf.neg_y ? -offys : offys);
    on_d  = (sx >= 0) && (sx <= $signed(wts_pkg::SumW'({vp_w, 4'b0000})))
         && (sy >= 0) && (sy <= $signed(wts_pkg::SumW'({vp_h, 4'b0000})));
    cx    = clamp20(sx);
    cy    = clamp20(sy);
  end

  // output register
  logic                            ok_q, on_q;
  logic signed [wts_pkg::ScrW-1:0] scx_q, scy_q;
  logic [wts_pkg::DepthW-1:0]      dep_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en) begin
      out_vld_q <= vdl_q[DivLat-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      // rejected points give an all-zero item
      ok_q  <= sf.ok;
      on_q  <= sf.ok && on_d;
      scx_q <= sf.ok ? cx : '0;
      scy_q <= sf.ok ? cy : '0;
      dep_q <= sf.ok ? sf.depth : '0;
    end
  end

  assign res_o.valid        = out_vld_q;
  assign res_o.projected_ok = ok_q;
  assign res_o.screen_x     = scx_q;
  assign res_o.screen_y     = scy_q;
  assign res_o.depth        = dep_q;
  assign res_o.on_screen    = on_q;

  a_reject_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && !res_o.projected_ok |->
      res_o.screen_x == 0 && res_o.screen_y == 0 && res_o.depth == 0 && !res_o.on_screen)
    else $error("rejected item carries non-zero fields");

  a_on_needs_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && res_o.on_screen |-> res_o.projected_ok)
    else $error("on-screen flag without projection");

  a_ready_follows_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pt_i.ready == (!res_o.valid || res_o.ready))
    else $error("input ready out of step with output slot");

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(vld_q) && $stable(vdl_q))
    else $error("pipeline valid bits moved during a stall");

endmodule
